FILE: design/assert_macros.svh
// Assertion helpers shared by the letterbox detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lbd_pkg.sv
package lbd_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SIZE_W     = 12;
  localparam int SENS_W     = 10;
  localparam int EDGE_W     = 11;
  localparam int SUM_W      = 21;
  localparam int PIX_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int SUG_W      = 12;
  localparam int PROD_W     = 32;
  localparam int K_W        = 20;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [SUG_W-1:0] SUG_NONE = '1;

  // mean > sens/1000 of full scale, scaled up to stay in integers
  localparam int SCALE      = 1000;
  localparam int FULL_SCALE = 765;

  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 12'd1920;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 12'd1080;
  localparam logic [SENS_W-1:0] RST_SENSITIVITY  = 10'd10;
  localparam logic              RST_STABILITY    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STABILITY    = 2'd3;

  // cycles for the threshold products to follow a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_ROW,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } lbd_state_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic row;
    logic scan;
    logic commit;
  } lbd_cmd_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic scan_last;
  } lbd_status_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic logic bright(input logic [SUM_W-1:0] sum,
                                  input logic [PROD_W-1:0] thr);
    logic [PROD_W-1:0] lhs;
    lhs = PROD_W'(sum) * PROD_W'(SCALE);
    return lhs > thr;
  endfunction

endpackage

FILE: design/lbd_ram.sv
module lbd_ram #(
  parameter int WIDTH = lbd_pkg::SUM_W,
  parameter int DEPTH = lbd_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lbd_datapath.sv
`include "assert_macros.svh"

module lbd_datapath #(
  parameter int MAX_WIDTH  = lbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [lbd_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  input  lbd_pkg::lbd_cmd_t                cmd,
  output lbd_pkg::lbd_status_t             status,
  output logic [lbd_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import lbd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WC_W  = $clog2(MAX_WIDTH + 1);
  localparam int HC_W  = $clog2(MAX_HEIGHT + 1);
  localparam int PAD_W = OUT_DATA_W - 4*EDGE_W - 1;

  localparam int RST_W_EFF = (int'(RST_FRAME_WIDTH) > MAX_WIDTH) ?
                             MAX_WIDTH : int'(RST_FRAME_WIDTH);
  localparam int RST_H_EFF = (int'(RST_FRAME_HEIGHT) > MAX_HEIGHT) ?
                             MAX_HEIGHT : int'(RST_FRAME_HEIGHT);

  // configuration
  logic [SIZE_W-1:0] width_r, height_r;
  logic [SENS_W-1:0] sens_r;
  logic              stab_r;

  // derived sizes and thresholds
  logic [WC_W-1:0]   w_eff_nxt, w_eff_r;
  logic [HC_W-1:0]   h_eff_nxt, h_eff_r;
  logic [K_W-1:0]    k_r;
  logic [PROD_W-1:0] thr_w_r, thr_h_r;

  // per-frame accumulation
  logic [PIX_W-1:0]  px_nxt, px_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SUM_W-1:0]  row_sum_r;
  logic [WC_W-1:0]   fill_r;
  logic              row_found_r;
  logic [ROW_W-1:0]  first_r, last_r;

  // column scan
  logic [COL_W-1:0]  scan_x_r, rd_x_r;
  logic              rd_pend_r;
  logic              col_found_r;
  logic [COL_W-1:0]  nl_r, nr_r;

  // edges
  logic [ROW_W-1:0]  top_r, bottom_r;
  logic [COL_W-1:0]  left_r, right_r;
  logic [SUG_W-1:0]  sug_t_r, sug_b_r, sug_l_r, sug_r_r;

  // result payload
  logic [EDGE_W-1:0] o_top_r, o_bottom_r, o_left_r, o_right_r;
  logic              o_rej_r;

  // RAM
  logic [COL_W-1:0]  ram_raddr;
  logic [SUM_W-1:0]  ram_rdata, ram_wdata, col_old, scan_sum;

  logic              row_end, frame_end, scan_last;
  logic [ROW_W-1:0]  cand_t, cand_b, new_t, new_b;
  logic [COL_W-1:0]  cand_l, cand_r, new_l, new_r;
  logic              reject;
  logic              chg_t, chg_b, chg_l, chg_r;
  logic              take_t, take_b, take_l, take_r;

  lbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      sens_r   <= RST_SENSITIVITY;
      stab_r   <= RST_STABILITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_SENSITIVITY:  sens_r   <= cfg_wdata[SENS_W-1:0];
        CFG_STABILITY:    stab_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff_nxt = WC_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff_nxt = WC_W'(MAX_WIDTH);
    end else begin
      w_eff_nxt = WC_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff_nxt = HC_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff_nxt = HC_W'(MAX_HEIGHT);
    end else begin
      h_eff_nxt = HC_W'(height_r);
    end
  end

  // sensitivity product first, then the width and height threshold products from it
  always_ff @(posedge clk) begin
    w_eff_r <= w_eff_nxt;
    h_eff_r <= h_eff_nxt;
    k_r     <= K_W'(sens_r) * K_W'(FULL_SCALE);
    thr_w_r <= PROD_W'(k_r) * PROD_W'(w_eff_r);
    thr_h_r <= PROD_W'(k_r) * PROD_W'(h_eff_r);
  end

  assign px_nxt = PIX_W'(in_tdata[BYTE_W-1:0]) + PIX_W'(in_tdata[2*BYTE_W-1:BYTE_W])
                + PIX_W'(in_tdata[3*BYTE_W-1:2*BYTE_W]);

  assign ram_raddr = cmd.load ? (in_tuser ? '0 : col_r) : scan_x_r;

  // columns at or past the fill mark are not yet written this frame
  assign col_old   = (WC_W'(col_r) < fill_r) ? ram_rdata : '0;
  assign ram_wdata = sat_add(col_old, px_r);
  assign scan_sum  = (WC_W'(rd_x_r) < fill_r) ? ram_rdata : '0;

  assign row_end   = (WC_W'(col_r) + WC_W'(1)) >= w_eff_r;
  assign frame_end = (HC_W'(row_r) + HC_W'(1)) >= h_eff_r;
  assign scan_last = (WC_W'(scan_x_r) + WC_W'(1)) >= w_eff_r;

  assign status.row_end   = row_end;
  assign status.frame_end = frame_end;
  assign status.scan_last = scan_last;

  // frame decision
  always_comb begin
    cand_t = row_found_r ? first_r : top_r;
    cand_b = row_found_r ? last_r  : bottom_r;
    cand_l = col_found_r ? nl_r    : left_r;
    cand_r = col_found_r ? nr_r    : right_r;
    reject = (HC_W'(cand_t) >= h_eff_r) || (HC_W'(cand_b) > h_eff_r) ||
             (cand_t >= cand_b) || (WC_W'(cand_r) >= w_eff_r) ||
             (WC_W'(cand_l) > w_eff_r) || (cand_l >= cand_r);
    chg_t  = cand_t != top_r;
    chg_b  = cand_b != bottom_r;
    chg_l  = cand_l != left_r;
    chg_r  = cand_r != right_r;
    take_t = !reject && chg_t && (!stab_r || SUG_W'(cand_t) == sug_t_r);
    take_b = !reject && chg_b && (!stab_r || SUG_W'(cand_b) == sug_b_r);
    take_l = !reject && chg_l && (!stab_r || SUG_W'(cand_l) == sug_l_r);
    take_r = !reject && chg_r && (!stab_r || SUG_W'(cand_r) == sug_r_r);
    new_t  = take_t ? cand_t : top_r;
    new_b  = take_b ? cand_b : bottom_r;
    new_l  = take_l ? cand_l : left_r;
    new_r  = take_r ? cand_r : right_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      row_sum_r   <= '0;
      fill_r      <= '0;
      row_found_r <= 1'b0;
      scan_x_r    <= '0;
      rd_pend_r   <= 1'b0;
      col_found_r <= 1'b0;
      top_r       <= '0;
      bottom_r    <= ROW_W'(RST_H_EFF - 1);
      left_r      <= '0;
      right_r     <= COL_W'(RST_W_EFF - 1);
      sug_t_r     <= SUG_NONE;
      sug_b_r     <= SUG_NONE;
      sug_l_r     <= SUG_NONE;
      sug_r_r     <= SUG_NONE;
    end else begin
      rd_pend_r <= cmd.scan;

      if (cmd.load && in_tuser) begin
        col_r       <= '0;
        row_r       <= '0;
        row_sum_r   <= '0;
        fill_r      <= '0;
        row_found_r <= 1'b0;
      end

      if (cmd.acc) begin
        row_sum_r <= sat_add(row_sum_r, px_r);
        if (WC_W'(col_r) >= fill_r) begin
          fill_r <= WC_W'(col_r) + WC_W'(1);
        end
        col_r <= row_end ? '0 : col_r + COL_W'(1);
      end

      if (cmd.row) begin
        if (bright(row_sum_r, thr_w_r)) begin
          row_found_r <= 1'b1;
        end
        row_sum_r <= '0;
        if (frame_end) begin
          scan_x_r    <= '0;
          col_found_r <= 1'b0;
        end else begin
          row_r <= row_r + ROW_W'(1);
        end
      end

      if (cmd.scan) begin
        scan_x_r <= scan_x_r + COL_W'(1);
      end

      if (rd_pend_r && bright(scan_sum, thr_h_r)) begin
        col_found_r <= 1'b1;
      end

      if (cmd.commit) begin
        if (take_t) top_r    <= cand_t;
        if (take_b) bottom_r <= cand_b;
        if (take_l) left_r   <= cand_l;
        if (take_r) right_r  <= cand_r;
        if (!reject && chg_t && !take_t) sug_t_r <= SUG_W'(cand_t);
        if (!reject && chg_b && !take_b) sug_b_r <= SUG_W'(cand_b);
        if (!reject && chg_l && !take_l) sug_l_r <= SUG_W'(cand_l);
        if (!reject && chg_r && !take_r) sug_r_r <= SUG_W'(cand_r);
        col_r       <= '0;
        row_r       <= '0;
        row_sum_r   <= '0;
        fill_r      <= '0;
        row_found_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= px_nxt;
    end
    if (cmd.row && bright(row_sum_r, thr_w_r)) begin
      if (!row_found_r) begin
        first_r <= row_r;
      end
      last_r <= row_r;
    end
    if (cmd.scan) begin
      rd_x_r <= scan_x_r;
    end
    if (rd_pend_r && bright(scan_sum, thr_h_r)) begin
      if (!col_found_r) begin
        nl_r <= rd_x_r;
      end
      nr_r <= rd_x_r;
    end
    if (cmd.commit) begin
      o_top_r    <= EDGE_W'(new_t);
      o_bottom_r <= EDGE_W'(new_b);
      o_left_r   <= EDGE_W'(new_l);
      o_right_r  <= EDGE_W'(new_r);
      o_rej_r    <= reject;
    end
  end

  assign out_tdata = {{PAD_W{1'b0}}, o_rej_r, o_right_r, o_left_r, o_bottom_r, o_top_r};

  `ASSERT_IMPLY(a_row_order, clk, rst_n, row_found_r, first_r <= last_r, "first bright row after last")
  `ASSERT_IMPLY(a_col_order, clk, rst_n, col_found_r, nl_r <= nr_r, "left column past right column")
  `ASSERT_NEXT(a_frame_clear, clk, rst_n, cmd.commit, fill_r == '0 && !row_found_r, "frame state not cleared")

endmodule

FILE: design/lbd_ctrl.sv
`include "assert_macros.svh"

module lbd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output lbd_pkg::lbd_cmd_t    cmd,
  input  lbd_pkg::lbd_status_t status
);
  import lbd_pkg::*;

  lbd_state_t state_r, state_nxt;
  logic [1:0] settle_r, settle_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      settle_r    <= SETTLE_CYCLES;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      settle_r    <= settle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    ready     = (state_r == ST_IDLE) && (settle_r == '0);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = status.row_end ? ST_ROW : ST_IDLE;
      end
      ST_ROW: begin
        cmd.row   = 1'b1;
        state_nxt = status.frame_end ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_tready  = ready;
  assign out_tvalid = out_valid_r;

  `ASSERT_NEXT(a_accept_acc, clk, rst_n, in_tvalid && in_tready, state_r == ST_ACC, "accepted word not taken into accumulate")
  `ASSERT_NEXT(a_cfg_settle, clk, rst_n, cfg_we, !in_tready, "word accepted before thresholds settled")

endmodule

FILE: design/letterbox_border_detector.sv
// Channel  | Ports                              | Word
// ---------+------------------------------------+------------------------------------------
// in       | in_tvalid/in_tready/in_tdata/tuser | one pixel, tuser = start of frame
// out      | out_tvalid/out_tready/out_tdata    | edges of one finished frame
// cfg      | cfg_we/cfg_index/cfg_wdata         | register write, no handshake back
//
// A pixel: column RAM read on acceptance, then add and write back; the last
// pixel of a row also gets the row brightness test.
// After the last pixel of a frame the column scan reads one RAM word per cycle,
// then the drain state ends the read and the decide state commits the edges.
// Reset is synchronous, active low; in_tready stays low after reset
// and after any register write while the threshold products settle.
// The result is held in an output register; pixels keep flowing while it
// waits, and only the next frame's decision waits for out_tready.
module letterbox_border_detector #(
  parameter int MAX_WIDTH  = lbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbd_pkg::CFG_W-1:0]       cfg_wdata,
  // pixel stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lbd_pkg::IN_DATA_W-1:0]   in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                            in_tuser,   // start_of_frame
  // frame results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lbd_pkg::OUT_DATA_W-1:0]  out_tdata   // top[10:0], bottom[21:11],
                                                      // left[32:22], right[43:33],
                                                      // candidate_rejected[44], zeros
);
  import lbd_pkg::*;

  lbd_cmd_t    cmd;
  lbd_status_t status;

  // sequencer: accept, accumulate, row test, column scan, decide
  lbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  // sums, column RAM, edge registers and result payload
  lbd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

FILE: tb/tb_letterbox_border_detector.sv
`timescale 1ns / 1ps

module tb_letterbox_border_detector;
  import lbd_pkg::*;

  localparam int MAX_W   = DEF_MAX_WIDTH;
  localparam int MAX_H   = DEF_MAX_HEIGHT;
  localparam int N_RAND  = 750;   // random pixels after the directed frames
  localparam int HOLD_CY = 600;   // long result hold-off, in clock cycles

  // One pixel word as it goes into in_tdata / in_tuser
  typedef struct packed {
    logic       sof;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Result word, laid out exactly as the low bits of out_tdata
  typedef struct packed {
    logic              rejected;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] bottom;
    logic [EDGE_W-1:0] top;
  } frame_edges_t;

  // How a generated frame is painted
  typedef enum {SH_DARK, SH_WHITE, SH_BOX, SH_GLOW, SH_NOISE} shade_e;

  // One directed frame: register values, picture, pixel count, and the
  // expected result where it can be written down by hand
  typedef struct {
    int           w, h, sens;
    bit           stab;
    shade_e       shade;
    int           bt, bb, bl, br;
    int           npix;        // 0 = whole frame
    bit           sof;
    bit           typed;
    frame_edges_t want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // red[7:0], green[15:8], blue[23:16]
  logic                  in_tuser = 1'b0;  // start_of_frame
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // top[10:0], bottom[21:11], left[32:22],
                                           // right[43:33], candidate_rejected[44]

  letterbox_border_detector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Border predictor: own copy of the registers and the per-frame state
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] m_width;
  logic [SIZE_W-1:0] m_height;
  logic [SENS_W-1:0] m_sens;
  logic              m_stab;

  int unsigned col_sum [MAX_W];
  int unsigned row_acc;
  int unsigned px_col;
  int unsigned px_row;
  bit          row_hit;
  int unsigned first_row;
  int unsigned last_row;
  int unsigned edge_now  [4];   // top, bottom, left, right
  int unsigned edge_sugg [4];

  frame_edges_t pending_edges [$];   // results still owed by the block
  bit           typed_pending;       // next result is the hand-written one
  frame_edges_t typed_want;

  int mismatch_count;
  int frames_seen;
  int pixels_sent;

  function automatic int unsigned eff_dim(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
    return (a + b > SUM_MAX) ? SUM_MAX : a + b;
  endfunction

  // mean > sens/1000 of full scale, kept exact in integers
  function automatic bit is_lit(int unsigned sum, int unsigned count);
    longint unsigned lhs, rhs;
    lhs = 64'(sum) * 64'(SCALE);
    rhs = 64'(FULL_SCALE) * 64'(m_sens) * 64'(count);
    return lhs > rhs;
  endfunction

  function automatic void clear_frame();
    foreach (col_sum[i]) col_sum[i] = 0;
    row_acc   = 0;
    px_col    = 0;
    px_row    = 0;
    row_hit   = 1'b0;
    first_row = 0;
    last_row  = 0;
  endfunction

  function automatic void border_reset();
    m_width  = RST_FRAME_WIDTH;
    m_height = RST_FRAME_HEIGHT;
    m_sens   = RST_SENSITIVITY;
    m_stab   = RST_STABILITY;
    clear_frame();
    edge_now[0] = 0;
    edge_now[1] = eff_dim(m_height, MAX_H) - 1;
    edge_now[2] = 0;
    edge_now[3] = eff_dim(m_width, MAX_W) - 1;
    foreach (edge_sugg[i]) edge_sugg[i] = SUG_NONE;
  endfunction

  // With stability on an edge only moves once the same candidate turns up twice
  function automatic void move_edge(int i, int unsigned cand);
    if (cand != edge_now[i]) begin
      if (!m_stab || cand == edge_sugg[i]) edge_now[i] = cand;
      else edge_sugg[i] = cand & SUG_NONE;
    end
  endfunction

  // Takes one pixel; returns 1 with the result when it closes a frame
  function automatic bit border_pixel(pixel_t p, output frame_edges_t r);
    int unsigned w, h, px;
    int unsigned cand [4];
    bit col_hit, reject;
    r = '0;
    if (p.sof) clear_frame();
    w  = eff_dim(m_width, MAX_W);
    h  = eff_dim(m_height, MAX_H);
    px = int'(p.red) + int'(p.green) + int'(p.blue);
    row_acc = sat_sum(row_acc, px);
    col_sum[px_col] = sat_sum(col_sum[px_col], px);
    if (px_col + 1 < w) begin
      px_col++;
      return 1'b0;
    end
    // row finished
    if (is_lit(row_acc, w)) begin
      if (!row_hit) first_row = px_row;
      row_hit  = 1'b1;
      last_row = px_row;
    end
    row_acc = 0;
    px_col  = 0;
    if (px_row + 1 < h) begin
      px_row++;
      return 1'b0;
    end
    // frame finished: no bright line means the current edge stands as candidate
    foreach (cand[i]) cand[i] = edge_now[i];
    if (row_hit) begin
      cand[0] = first_row;
      cand[1] = last_row;
    end
    col_hit = 1'b0;
    for (int unsigned x = 0; x < w; x++) begin
      if (is_lit(col_sum[x], h)) begin
        if (!col_hit) cand[2] = x;
        col_hit = 1'b1;
        cand[3] = x;
      end
    end
    reject = (cand[0] >= h) || (cand[1] > h) || (cand[0] >= cand[1]) ||
             (cand[3] >= w) || (cand[2] > w) || (cand[2] >= cand[3]);
    if (!reject) for (int i = 0; i < 4; i++) move_edge(i, cand[i]);
    r.top      = EDGE_W'(edge_now[0]);
    r.bottom   = EDGE_W'(edge_now[1]);
    r.left     = EDGE_W'(edge_now[2]);
    r.right    = EDGE_W'(edge_now[3]);
    r.rejected = reject;
    clear_frame();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 60)
      $display("%0t ns: frame %0d %s: got %0d, want %0d", $time, frames_seen, what, got,
               want);
  endtask

  always @(posedge clk) begin
    frame_edges_t got;
    frame_edges_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(frame_edges_t)-1:0];
      if (pending_edges.size() == 0) begin
        note_mismatch("result with none pending", 1, 0);
      end else begin
        want = pending_edges.pop_front();
        if (got.top != want.top)           note_mismatch("top_edge", got.top, want.top);
        if (got.bottom != want.bottom)     note_mismatch("bottom_edge", got.bottom, want.bottom);
        if (got.left != want.left)         note_mismatch("left_edge", got.left, want.left);
        if (got.right != want.right)       note_mismatch("right_edge", got.right, want.right);
        if (got.rejected != want.rejected) note_mismatch("candidate_rejected", got.rejected,
                                                         want.rejected);
        if (out_tdata[OUT_DATA_W-1:$bits(frame_edges_t)] != '0)
          note_mismatch("padding", int'(out_tdata[OUT_DATA_W-1:$bits(frame_edges_t)]), 0);
      end
      frames_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern picked by bits 7:6 of a free-running tick count, plus an
  // occasional long hold-off so the block backs up into in_tready
  // ---------------------------------------------------------------------------
  logic [31:0] ready_tick = '0;
  bit          hold_pending;
  int          hold_left;

  always @(negedge clk) begin
    ready_tick++;
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CY;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_tick[7:6])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= 1'($urandom_range(0, 1));
        2'd2:    out_tready <= (ready_tick[1:0] == 2'd0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side
  // ---------------------------------------------------------------------------
  int burst_left;

  // Offers one word in bursts with random gaps; long bursts now and then
  task automatic push_pixel(pixel_t p);
    frame_edges_t r;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 250)
                                               : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {p.blue, p.green, p.red};
    in_tuser  <= p.sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    burst_left--;
    if (border_pixel(p, r)) begin
      if (typed_pending) begin
        pending_edges.push_back(typed_want);
        typed_pending = 1'b0;
      end else begin
        pending_edges.push_back(r);
      end
    end
  endtask

  // Paints a w x h frame; npix > 0 cuts it short, stray puts a start mark
  // on that pixel index as well
  task automatic send_frame(shade_e sh, int w, int h, int bt, int bb, int bl, int br,
                            int npix, bit sof, int stray);
    pixel_t p;
    int     n;
    bit     in_box;
    n = 0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (npix > 0 && n >= npix) return;
        in_box = (y >= bt) && (y <= bb) && (x >= bl) && (x <= br);
        p.sof  = (n == 0) ? sof : (n == stray);
        case (sh)
          SH_DARK:  {p.red, p.green, p.blue} = '0;
          SH_WHITE: {p.red, p.green, p.blue} = '1;
          SH_BOX:   {p.red, p.green, p.blue} = in_box ? '1 : '0;
          SH_GLOW: begin
            p.red   = in_box ? $urandom_range(90, 255) : $urandom_range(0, 6);
            p.green = in_box ? $urandom_range(90, 255) : $urandom_range(0, 6);
            p.blue  = in_box ? $urandom_range(90, 255) : $urandom_range(0, 6);
          end
          default: begin
            p.red   = $urandom_range(0, 255);
            p.green = $urandom_range(0, 255);
            p.blue  = $urandom_range(0, 255);
          end
        endcase
        push_pixel(p);
        n++;
      end
    end
  endtask

  // Registers only move with the block idle: all results in, last pixel done
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    case (idx)
      CFG_FRAME_WIDTH:  m_width  = SIZE_W'(val);
      CFG_FRAME_HEIGHT: m_height = SIZE_W'(val);
      CFG_SENSITIVITY:  m_sens   = SENS_W'(val);
      CFG_STABILITY:    m_stab   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int w, int h, int sens, bit stab);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_SENSITIVITY, sens);
    write_reg(CFG_STABILITY, stab);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic plan_row_t row_of(int w, int h, int sens, bit stab, shade_e sh,
                                       int bt, int bb, int bl, int br, int npix, bit sof,
                                       bit typed, int t, int b, int l, int r, bit rej);
    plan_row_t row;
    row.w     = w;
    row.h     = h;
    row.sens  = sens;
    row.stab  = stab;
    row.shade = sh;
    row.bt    = bt;
    row.bb    = bb;
    row.bl    = bl;
    row.br    = br;
    row.npix  = npix;
    row.sof   = sof;
    row.typed = typed;
    row.want  = '{rejected: rej, right: EDGE_W'(r), left: EDGE_W'(l),
                  bottom: EDGE_W'(b), top: EDGE_W'(t)};
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  plan_row_t plan [$];

  initial begin
    plan_row_t r;
    shade_e    sh;
    int        rand_start, w, h, sens, nfr, bt, bb, bl, br, npix, stray;
    bit        stab, second_hold;

    border_reset();

    // Directed frames. Columns: width, height, sensitivity, stability, shade,
    // box top/bottom/left/right, pixel count, sof, typed, then the typed result
    // top/bottom/left/right/rejected. Edges start from the reset frame size.
    // all dark: candidates are the reset edges, bottom 1079 > height, so rejected
    plan.push_back(row_of(4, 4, 10, 1, SH_DARK, 0, 0, 0, 0, 0, 1, 1, 0, 1079, 0, 1919, 1));
    // all bright: bottom/right only suggested on the first sighting
    plan.push_back(row_of(4, 4, 10, 1, SH_WHITE, 0, 0, 0, 0, 0, 1, 1, 0, 1079, 0, 1919, 0));
    plan.push_back(row_of(4, 4, 10, 1, SH_WHITE, 0, 0, 0, 0, 0, 1, 1, 0, 3, 0, 3, 0));
    // inner box seen twice, second time with no frame start mark
    plan.push_back(row_of(4, 4, 10, 1, SH_BOX, 1, 2, 1, 2, 0, 1, 1, 0, 3, 0, 3, 0));
    plan.push_back(row_of(4, 4, 10, 1, SH_BOX, 1, 2, 1, 2, 0, 0, 1, 1, 2, 1, 2, 0));
    // stability off: edges jump at once
    plan.push_back(row_of(4, 4, 10, 0, SH_BOX, 0, 3, 0, 1, 0, 1, 1, 0, 3, 0, 1, 0));
    // a single bright row, then a single bright column: top == bottom, left == right
    plan.push_back(row_of(4, 4, 10, 0, SH_BOX, 2, 2, 0, 3, 0, 1, 1, 0, 3, 0, 1, 1));
    plan.push_back(row_of(4, 4, 10, 0, SH_BOX, 0, 3, 1, 1, 0, 1, 1, 0, 3, 0, 1, 1));
    // sensitivity at and past full scale: nothing is bright, edges kept
    plan.push_back(row_of(4, 4, 1000, 0, SH_WHITE, 0, 0, 0, 0, 0, 1, 1, 0, 3, 0, 1, 0));
    plan.push_back(row_of(4, 4, 1023, 0, SH_WHITE, 0, 0, 0, 0, 0, 1, 1, 0, 3, 0, 1, 0));
    // zero sensitivity: any light counts
    plan.push_back(row_of(4, 4, 0, 0, SH_NOISE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    // a frame cut off after six pixels, then the width shrinks under it
    plan.push_back(row_of(4, 4, 10, 1, SH_WHITE, 0, 0, 0, 0, 6, 1, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_of(2, 4, 10, 1, SH_NOISE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // restart mark in mid frame
    plan.push_back(row_of(5, 3, 10, 1, SH_WHITE, 0, 0, 0, 0, 7, 1, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_of(5, 3, 10, 1, SH_NOISE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    // zero sizes act as one pixel
    plan.push_back(row_of(0, 0, 10, 1, SH_WHITE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    // oversize registers clamp to the maximum
    plan.push_back(row_of(4095, 1, 300, 1, SH_NOISE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_of(1, 4095, 300, 0, SH_NOISE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    // widest legal frame, box well inside it
    plan.push_back(row_of(2048, 2, 10, 0, SH_BOX, 0, 1, 5, 2000, 0, 1, 1, 0, 1, 5, 2000, 0));
    plan.push_back(row_of(5, 3, 500, 1, SH_NOISE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      r = plan[i];
      if (r.w != m_width || r.h != m_height || r.sens != m_sens || r.stab != m_stab)
        set_regs(r.w, r.h, r.sens, r.stab);
      typed_pending = r.typed;
      typed_want    = r.want;
      send_frame(r.shade, eff_dim(SIZE_W'(r.w), MAX_W), eff_dim(SIZE_W'(r.h), MAX_H),
                 r.bt, r.bb, r.bl, r.br, r.npix, r.sof, -1);
      typed_pending = 1'b0;
    end

    // Random part: each phase a fresh setting, then a few frames of a glowing
    // box on a dark ground so that the stability logic gets to move edges.
    // Some noise, flat frames, stray start marks and cut-off frames mixed in.
    hold_pending = 1'b1;
    second_hold  = 1'b0;
    rand_start   = pixels_sent;
    while (pixels_sent - rand_start < N_RAND) begin
      if (!second_hold && pixels_sent - rand_start > N_RAND / 2) begin
        hold_pending = 1'b1;
        second_hold  = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
      end
      sens = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 200);
      stab = 1'($urandom_range(0, 1));
      set_regs(w, h, sens, stab);
      nfr = $urandom_range(1, 4);
      for (int f = 0; f < nfr; f++) begin
        if (f == 0 || $urandom_range(0, 3) == 0) begin
          bt = $urandom_range(0, h - 1);
          bb = $urandom_range(bt, h - 1);
          bl = $urandom_range(0, w - 1);
          br = $urandom_range(bl, w - 1);
        end
        case ($urandom_range(0, 7))
          0:       sh = SH_NOISE;
          1:       sh = ($urandom_range(0, 1) == 0) ? SH_DARK : SH_WHITE;
          default: sh = SH_GLOW;
        endcase
        npix  = (f == nfr - 1 && w * h > 1 && $urandom_range(0, 5) == 0)
                ? $urandom_range(1, w * h - 1) : 0;
        stray = (w * h > 1 && $urandom_range(0, 15) == 0) ? $urandom_range(1, w * h - 1) : -1;
        send_frame(sh, w, h, bt, bb, bl, br, npix, ($urandom_range(0, 7) != 0), stray);
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lbd_pkg.sv
design/lbd_ram.sv
design/lbd_datapath.sv
design/lbd_ctrl.sv
design/letterbox_border_detector.sv
tb/tb_letterbox_border_detector.sv
